>>> src/min_window_sum_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the min window sum tracker RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_WINDOW_SUM_TRACKER_ASSERT_SVH
`define MIN_WINDOW_SUM_TRACKER_ASSERT_SVH

// invariant that holds on every enabled clock edge
`define MWST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MWST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mwst_pkg.sv
// ----------------------------------------------------------------------------
// mwst_pkg
// Shared constants and types of the min window sum tracker.
// ----------------------------------------------------------------------------
package mwst_pkg;

  localparam int LEN_W     = 9;
  localparam int OUT_SUM_W = 24;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // head of the request queue, seen by the back end
  typedef struct packed {
    logic valid;
    logic last;
  } qhead_t;

endpackage

>>> src/mwst_if.sv
// ----------------------------------------------------------------------------
// mwst_if
// Valid/ready channels of the min window sum tracker.
// ----------------------------------------------------------------------------
interface mwst_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          seq_end;

  modport source (output valid, output sample, output seq_end, input ready);
  modport sink (input valid, input sample, input seq_end, output ready);
endinterface

interface mwst_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mwst_pkg::OUT_SUM_W-1:0]  min_sum;
  logic                                   no_window;

  modport source (output valid, output min_sum, output no_window, input ready);
  modport sink (input valid, input min_sum, input no_window, output ready);
endinterface

interface mwst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mwst_pkg::LEN_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/mwst_front.sv
// ----------------------------------------------------------------------------
// mwst_front
// Accepts sample requests and queues them for the back end.
// ----------------------------------------------------------------------------
`include "min_window_sum_tracker_assert.svh"

module mwst_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mwst_in_if.sink                       in_ch,
  input  logic                          pop,
  output mwst_pkg::qhead_t              head,
  output logic signed [SAMPLE_BITS-1:0] head_sample
);

  logic signed [SAMPLE_BITS-1:0]  q_sample_r [mwst_pkg::QDEPTH];
  logic                           q_last_r   [mwst_pkg::QDEPTH];
  logic [mwst_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mwst_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mwst_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           push;

  assign in_ch.ready = (cnt_r != mwst_pkg::QCNT_W'(mwst_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid  = (cnt_r != '0);
  assign head.last   = q_last_r[rd_ptr_r];
  assign head_sample = q_sample_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_sample_r[wr_ptr_r] <= in_ch.sample;
      q_last_r[wr_ptr_r]   <= in_ch.seq_end;
    end
  end

  `MWST_ASSERT_IMPL(a_pop_nonempty, pop, cnt_r != '0, "pop from empty request queue")
  `MWST_ASSERT(a_cnt_range, cnt_r <= mwst_pkg::QCNT_W'(mwst_pkg::QDEPTH), "queue count overflow")

endmodule

>>> src/mwst_back.sv
// ----------------------------------------------------------------------------
// mwst_back
// Sample ring, running window sum, minimum tracking and result register.
// ----------------------------------------------------------------------------
`include "min_window_sum_tracker_assert.svh"

module mwst_back #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mwst_cfg_if.sink                      cfg_ch,
  input  mwst_pkg::qhead_t              head,
  input  logic signed [SAMPLE_BITS-1:0] head_sample,
  output logic                          pop,
  mwst_out_if.source                    out_ch
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int ACC_W  = SAMPLE_BITS + CNT_W;
  localparam int WIDE_W = (ACC_W > mwst_pkg::OUT_SUM_W) ? ACC_W : mwst_pkg::OUT_SUM_W;

  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic [CNT_W-1:0]              eff_len_r, eff_len_nxt;
  logic [31:0]                   len_ext;
  logic [PTR_W-1:0]              wp_r, wp_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [CNT_W:0]                wp_ext, len_x, old_full;
  logic [PTR_W-1:0]              old_addr;
  logic                          sub;

  logic                          a_v_r;
  logic signed [SAMPLE_BITS-1:0] a_sample_r, a_old_r;
  logic                          a_sub_r, a_full_r, a_last_r;
  logic                          a_go;

  logic signed [ACC_W-1:0]       sum_r, best_r, sum_new, best_new, old_term;
  logic                          have_r, have_new;
  logic signed [WIDE_W-1:0]      best_wide;

  logic                          out_v_r;
  logic signed [mwst_pkg::OUT_SUM_W-1:0] out_sum_r;
  logic                          out_nw_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    len_ext = 32'(cfg_ch.data);
    if (len_ext == 32'd0) begin
      eff_len_nxt = CNT_W'(1);
    end else if (len_ext > 32'(MAX_WINDOW)) begin
      eff_len_nxt = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len_nxt = CNT_W'(len_ext);
    end
  end

  // stage 1: ring access
  assign a_go = a_v_r && (!a_last_r || !out_v_r || out_ch.ready);
  assign pop  = head.valid && (!a_v_r || a_go);
  assign sub  = (fill_r >= eff_len_r);

  always_comb begin
    wp_ext   = (CNT_W+1)'(wp_r);
    len_x    = (CNT_W+1)'(eff_len_r);
    old_full = (wp_ext >= len_x) ? wp_ext - len_x
                                 : wp_ext + (CNT_W+1)'(MAX_WINDOW) - len_x;
    old_addr = PTR_W'(old_full);
    wp_nxt   = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
    fill_nxt = sub ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r <= CNT_W'(1);
      wp_r      <= '0;
      fill_r    <= '0;
      a_v_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        eff_len_r <= eff_len_nxt;
        wp_r      <= '0;
        fill_r    <= '0;
      end else if (pop) begin
        if (head.last) begin
          wp_r   <= '0;
          fill_r <= '0;
        end else begin
          wp_r   <= wp_nxt;
          fill_r <= fill_nxt;
        end
      end
      if (pop) begin
        a_v_r <= 1'b1;
      end else if (a_go) begin
        a_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ring_mem[wp_r] <= head_sample;
      a_old_r        <= ring_mem[old_addr];
      a_sample_r     <= head_sample;
      a_sub_r        <= sub;
      a_full_r       <= (fill_nxt >= eff_len_r);
      a_last_r       <= head.last;
    end
  end

  // stage 2: window sum and minimum
  always_comb begin
    old_term = a_sub_r ? {{(ACC_W-SAMPLE_BITS){a_old_r[SAMPLE_BITS-1]}}, a_old_r} : '0;
    sum_new  = sum_r + {{(ACC_W-SAMPLE_BITS){a_sample_r[SAMPLE_BITS-1]}}, a_sample_r}
               - old_term;
    best_new = best_r;
    if (a_full_r && (!have_r || (sum_new < best_r))) begin
      best_new = sum_new;
    end
    have_new  = have_r || a_full_r;
    best_wide = WIDE_W'(best_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      best_r  <= '0;
      have_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid || (a_go && a_last_r)) begin
        sum_r  <= '0;
        best_r <= '0;
        have_r <= 1'b0;
      end else if (a_go) begin
        sum_r  <= sum_new;
        best_r <= best_new;
        have_r <= have_new;
      end
      if (a_go && a_last_r) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_last_r) begin
      out_sum_r <= have_new ? best_wide[mwst_pkg::OUT_SUM_W-1:0] : '0;
      out_nw_r  <= !have_new;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.min_sum   = out_sum_r;
  assign out_ch.no_window = out_nw_r;

  `MWST_ASSERT(a_fill_le_len, fill_r <= eff_len_r, "fill count beyond window length")
  `MWST_ASSERT_IMPL(a_nw_zero, out_v_r && out_nw_r, out_sum_r == '0, "no_window with nonzero sum")
  `MWST_ASSERT_NEXT(a_stall_hold, a_v_r && a_last_r && out_v_r && !out_ch.ready, a_v_r, "final request lost")

endmodule

>>> src/min_window_sum_tracker.sv
// ----------------------------------------------------------------------------
// min_window_sum_tracker
// Minimum sum over all fixed-size sliding windows of a sample sequence.
// ----------------------------------------------------------------------------
// in_ch  : one request per sample (sample, seq_end); seq_end marks the last
//          sample of a sequence.
// out_ch : one result per sequence (min_sum, no_window), issued for the
//          request with seq_end set. no_window = 1 and min_sum = 0 when the
//          sequence held fewer samples than the window length.
// cfg_ch : writes window_len (0 acts as 1, values above MAX_WINDOW saturate);
//          always ready, write only while idle. A write restarts the sequence.
// Throughput: one sample per cycle outside the stall below. Each sample costs
//          one ring read and write, then one add/subtract and compare stage.
// Result path: the final request passes the request queue, then the ring
//          access stage into the output register.
// Reset: window length 1, sequence cleared; the ring needs no clearing.
// Stall: a held result stops only the next final sample at ring access; the
//          four-entry request queue behind it drops in_ch.ready when full.
// ----------------------------------------------------------------------------
module min_window_sum_tracker #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mwst_in_if.sink    in_ch,
  mwst_out_if.source out_ch,
  mwst_cfg_if.sink   cfg_ch
);

  mwst_pkg::qhead_t              head;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          pop;

  mwst_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .pop         (pop),
    .head        (head),
    .head_sample (head_sample)
  );

  mwst_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .head        (head),
    .head_sample (head_sample),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

>>> verif/mwst_checker.sv
// ----------------------------------------------------------------------------
// mwst_checker
// Watches the sample, result and length channels of the min window sum
// tracker, keeps its own model of the sliding window and checks each result
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mwst_checker (
  input  logic clk,
  input  logic rst_n,
  mwst_in_if   in_ch,
  mwst_out_if  out_ch,
  mwst_cfg_if  cfg_ch,
  output int   outstanding,
  output int   mismatches
);

  localparam int RING_DEPTH = 256;

  typedef struct packed {
    logic signed [mwst_pkg::OUT_SUM_W-1:0] min_sum;
    logic                                  no_window;
  } window_result_t;

  window_result_t             min_q[$];
  window_result_t             want;
  logic signed [15:0]         ring [RING_DEPTH];
  logic [7:0]                 ring_wp;
  logic [8:0]                 fill;
  int                         acc_sum;
  int                         low_sum;
  logic                       have_low;
  logic [mwst_pkg::LEN_W-1:0] win_len;
  int                         bad_count = 0;

  task automatic note_mismatch(input string what);
    bad_count++;
    $display("%0t checker: %s", $time, what);
  endtask

  function automatic int span();
    if (win_len == 0) return 1;
    if (win_len > RING_DEPTH) return RING_DEPTH;
    return int'(win_len);
  endfunction

  task automatic restart_seq();
    ring_wp  = '0;
    fill     = '0;
    acc_sum  = 0;
    low_sum  = 0;
    have_low = 1'b0;
  endtask

  task automatic take_sample(input logic signed [15:0] s, input logic last);
    int             n;
    logic [7:0]     old_ix;
    window_result_t r;
    n = span();
    if (int'(fill) >= n) begin
      old_ix  = ring_wp - 8'(n);
      acc_sum = acc_sum - int'(ring[old_ix]);
    end
    ring[ring_wp] = s;
    acc_sum       = acc_sum + int'(s);
    ring_wp       = ring_wp + 8'd1;
    if (int'(fill) < n) fill = fill + 9'd1;
    if (int'(fill) >= n) begin
      if (!have_low || acc_sum < low_sum) low_sum = acc_sum;
      have_low = 1'b1;
    end
    if (last) begin
      r.no_window = !have_low;
      r.min_sum   = have_low ? low_sum[mwst_pkg::OUT_SUM_W-1:0] : '0;
      min_q.push_back(r);
      restart_seq();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = mwst_pkg::LEN_W'(1);
      restart_seq();
      min_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (min_q.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = min_q.pop_front();
          if (out_ch.min_sum !== want.min_sum)
            note_mismatch($sformatf("min_sum got %0d want %0d",
                                    $signed(out_ch.min_sum), $signed(want.min_sum)));
          if (out_ch.no_window !== want.no_window)
            note_mismatch($sformatf("no_window got %0b want %0b",
                                    out_ch.no_window, want.no_window));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_len = cfg_ch.data;
        restart_seq();
      end
      if (in_ch.valid && in_ch.ready) take_sample(in_ch.sample, in_ch.seq_end);
    end
    outstanding <= min_q.size();
    mismatches  <= bad_count;
  end

endmodule

>>> verif/tb_min_window_sum_tracker.sv
// ----------------------------------------------------------------------------
// tb_min_window_sum_tracker
// Drives sample sequences and window length writes into the min window sum
// tracker with random gaps and result backpressure; a checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_min_window_sum_tracker;

  localparam int QUIET_LIMIT  = 2000;
  localparam int ITEM_TARGET  = 1900;
  localparam int DRAIN_CYCLES = 4;

  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;

  typedef enum int {KIND_FULL, KIND_SMALL, KIND_EDGE, KIND_MIN, KIND_MAX} sample_kind_t;

  logic clk;
  logic rst_n;
  logic tx_burst;
  logic rx_burst;
  int   outstanding;
  int   mismatches;
  int   items_sent = 0;
  int   quiet = 0;

  mwst_in_if #(.SAMPLE_BITS(16)) in_ch ();
  mwst_out_if                    out_ch ();
  mwst_cfg_if                    cfg_ch ();

  min_window_sum_tracker #(
    .MAX_WINDOW (256),
    .SAMPLE_BITS(16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  mwst_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[min_window_sum_tracker] ERROR");
      $finish;
    end
  end

  // result backpressure
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic signed [15:0] pick_sample(sample_kind_t kind);
    case (kind)
      KIND_SMALL: return 16'($signed($urandom_range(0, 64)) - 32);
      KIND_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      KIND_MIN:  return SAMPLE_MIN;
      KIND_MAX:  return SAMPLE_MAX;
      default:   return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [15:0] s, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.seq_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_seq(input int n, input sample_kind_t kind);
    for (int i = 0; i < n; i++) push_sample(pick_sample(kind), i == n - 1);
  endtask

  // hold input until every result is back and the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [mwst_pkg::LEN_W-1:0] len);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [mwst_pkg::LEN_W-1:0] len, input int nseq);
    int           eff;
    int           n;
    int           r;
    sample_kind_t kind;
    eff = (len == 0) ? 1 : ((len > 256) ? 256 : int'(len));
    // partial sequence that the length write throws away
    if ($urandom_range(0, 3) == 0) begin
      r = $urandom_range(1, 5);
      for (int i = 0; i < r; i++) push_sample(pick_sample(KIND_FULL), 1'b0);
    end
    write_len(len);
    for (int k = 0; k < nseq; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2)      n = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
      else if (r < 8) n = eff + $urandom_range(0, 6);
      else            n = eff + $urandom_range(7, 40);
      kind = sample_kind_t'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) kind = KIND_FULL;
      send_seq(n, kind);
    end
  endtask

  initial begin
    int                         r;
    logic [mwst_pkg::LEN_W-1:0] len;
    rst_n         <= 1'b0;
    tx_burst      <= 1'b0;
    rx_burst      <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.seq_end <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window length 1 out of reset
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b1);
    push_sample(16'sd0, 1'b1);
    // zero length acts as 1
    write_len(9'd0);
    push_sample(16'sd5, 1'b0);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd7, 1'b1);
    // short sequence, then exactly one window
    write_len(9'd3);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b1);
    send_seq(3, KIND_MIN);
    // length write drops the sequence in progress
    push_sample(16'sd100, 1'b0);
    push_sample(16'sd200, 1'b0);
    write_len(9'd2);
    push_sample(16'sd1, 1'b1);
    // lengths above the ring saturate
    write_len(9'd511);
    push_sample(-16'sd1, 1'b1);
    write_len(9'd257);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(16'sd0, 1'b1);
    write_len(9'd256);
    push_sample(SAMPLE_MAX, 1'b1);
    write_len(9'd2);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(16'sd1, 1'b1);

    // full ring at the sum extremes
    tx_burst <= 1'b1;
    write_len(9'd256);
    send_seq(256, KIND_MIN);
    tx_burst <= 1'b0;
    send_seq(256, KIND_MAX);
    send_seq(300, KIND_FULL);

    while (items_sent < ITEM_TARGET) begin
      tx_burst <= ($urandom_range(0, 3) == 0);
      rx_burst <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 14)       len = mwst_pkg::LEN_W'($urandom_range(1, 8));
      else if (r == 14) len = '0;
      else if (r < 17)  len = mwst_pkg::LEN_W'($urandom_range(9, 40));
      else if (r == 17) len = mwst_pkg::LEN_W'($urandom_range(41, 255));
      else if (r == 18) len = mwst_pkg::LEN_W'($urandom_range(256, 511));
      else              len = mwst_pkg::LEN_W'($urandom_range(1, 3));
      run_phase(len, (r == 17 || r == 18) ? 1 : $urandom_range(2, 6));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[min_window_sum_tracker] OK");
    end else begin
      $display("[min_window_sum_tracker] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/mwst_pkg.sv
src/mwst_if.sv
src/mwst_front.sv
src/mwst_back.sv
src/min_window_sum_tracker.sv
verif/mwst_checker.sv
verif/tb_min_window_sum_tracker.sv
